// File: hw/rtl/lcdws_pkg.sv
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types, codes and constants of the character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  // Request and pin-state payloads.
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic       line_select;
    logic [5:0] column;
    logic       shift_right;
  } in_t;

  typedef struct packed {
    logic        reg_select;
    logic        read_write;
    logic        enable;
    logic [7:0]  data_lines;
    logic [15:0] hold_us;
    logic        last;
  } out_t;

  // Request actions.
  localparam logic [2:0] ACT_INIT    = 3'd0;
  localparam logic [2:0] ACT_COMMAND = 3'd1;
  localparam logic [2:0] ACT_DATA    = 3'd2;
  localparam logic [2:0] ACT_SETPOS  = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;
  localparam logic [2:0] ACT_SHIFT   = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_FOUR_BIT     = 1'b0;
  localparam logic CFG_ENABLE_PULSE = 1'b1;

  localparam logic [9:0] ENABLE_PULSE_RESET = 10'd1000;
  localparam logic [3:0] MAX_COLUMN         = 4'd15;

  // Microcode operations.
  localparam logic [1:0] OP_WAIT   = 2'd0;  // one state, E low, data 0
  localparam logic [1:0] OP_STROBE = 2'd1;  // one strobe of the byte as given
  localparam logic [1:0] OP_SEND   = 2'd2;  // full byte, one or two strobes

  // Byte sources.
  localparam logic [1:0] SRC_CONST = 2'd0;
  localparam logic [1:0] SRC_INPUT = 2'd1;
  localparam logic [1:0] SRC_POS   = 2'd2;
  localparam logic [1:0] SRC_SHIFT = 2'd3;

  // Jump conditions.
  localparam logic [1:0] JMP_NEXT    = 2'd0;
  localparam logic [1:0] JMP_ALWAYS  = 2'd1;
  localparam logic [1:0] JMP_IF_8BIT = 2'd2;

  // Hold-after codes.
  localparam logic [2:0] HOLD_0     = 3'd0;
  localparam logic [2:0] HOLD_45    = 3'd1;
  localparam logic [2:0] HOLD_2000  = 3'd2;
  localparam logic [2:0] HOLD_10000 = 3'd3;
  localparam logic [2:0] HOLD_35000 = 3'd4;

  // Bus constants.
  localparam logic [7:0] LCD_FSET_8BIT   = 8'b0011_1000;
  localparam logic [7:0] LCD_FSET_4BIT   = 8'b0010_1000;
  localparam logic [7:0] LCD_DISPLAY_ON  = 8'b0000_1100;
  localparam logic [7:0] LCD_ERASE_ALL   = 8'b0000_0001;
  localparam logic [7:0] LCD_ENTRY_MODE  = 8'b0000_0110;
  localparam logic [7:0] LCD_SCROLL_LEFT = 8'b0001_1000;
  localparam logic [7:0] LCD_SHIFT_BIT   = 8'b0000_0100;  // 0x1C for right
  localparam logic [7:0] LCD_LINE1_BASE  = 8'h80;
  localparam logic [7:0] LCD_LINE2_BASE  = 8'hC0;
  localparam logic [3:0] LCD_NIBBLE_4BIT = 4'b0010;

  // Microcode addresses.
  localparam logic [3:0] UA_INIT    = 4'd0;
  localparam logic [3:0] UA_INIT_8  = 4'd3;
  localparam logic [3:0] UA_INIT_CM = 4'd4;
  localparam logic [3:0] UA_COMMAND = 4'd7;
  localparam logic [3:0] UA_DATA    = 4'd8;
  localparam logic [3:0] UA_SETPOS  = 4'd9;
  localparam logic [3:0] UA_CLEAR   = 4'd10;
  localparam logic [3:0] UA_SHIFT   = 4'd11;

  // One microcode word.
  typedef struct packed {
    logic [1:0] op;
    logic [1:0] src;
    logic [7:0] byte_const;
    logic       rs;
    logic [2:0] hold_code;
    logic [1:0] jcond;
    logic [3:0] target;
    logic       done;
  } ucw_t;

  function automatic logic [15:0] hold_value(input logic [2:0] code);
    logic [15:0] v;
    case (code)
      HOLD_0:     v = 16'd0;
      HOLD_45:    v = 16'd45;
      HOLD_2000:  v = 16'd2000;
      HOLD_10000: v = 16'd10000;
      HOLD_35000: v = 16'd35000;
      default:    v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] entry_addr(input logic [2:0] action);
    logic [3:0] a;
    case (action)
      ACT_INIT:    a = UA_INIT;
      ACT_COMMAND: a = UA_COMMAND;
      ACT_DATA:    a = UA_DATA;
      ACT_SETPOS:  a = UA_SETPOS;
      ACT_CLEAR:   a = UA_CLEAR;
      ACT_SHIFT:   a = UA_SHIFT;
      default:     a = UA_INIT;
    endcase
    return a;
  endfunction

endpackage

// File: hw/rtl/lcdws_ucode_rom.sv
// ----------------------------------------------------------------------------
// lcdws_ucode_rom
// Microcode program of the sequencer, one word per step.
// ----------------------------------------------------------------------------
module lcdws_ucode_rom (
  input  logic [3:0]     addr,
  output lcdws_pkg::ucw_t word
);

  always_comb begin
    case (addr)
      // Init: power-up wait, then branch on bus width.
      4'd0:  word = '{lcdws_pkg::OP_WAIT, lcdws_pkg::SRC_CONST, 8'h00, 1'b0,
                      lcdws_pkg::HOLD_35000, lcdws_pkg::JMP_IF_8BIT,
                      lcdws_pkg::UA_INIT_8, 1'b0};
      4'd1:  word = '{lcdws_pkg::OP_STROBE, lcdws_pkg::SRC_CONST,
                      {lcdws_pkg::LCD_NIBBLE_4BIT, 4'h0}, 1'b0,
                      lcdws_pkg::HOLD_0, lcdws_pkg::JMP_NEXT, 4'd0, 1'b0};
      4'd2:  word = '{lcdws_pkg::OP_SEND, lcdws_pkg::SRC_CONST,
                      lcdws_pkg::LCD_FSET_4BIT, 1'b0, lcdws_pkg::HOLD_45,
                      lcdws_pkg::JMP_ALWAYS, lcdws_pkg::UA_INIT_CM, 1'b0};
      4'd3:  word = '{lcdws_pkg::OP_SEND, lcdws_pkg::SRC_CONST,
                      lcdws_pkg::LCD_FSET_8BIT, 1'b0, lcdws_pkg::HOLD_45,
                      lcdws_pkg::JMP_NEXT, 4'd0, 1'b0};
      4'd4:  word = '{lcdws_pkg::OP_SEND, lcdws_pkg::SRC_CONST,
                      lcdws_pkg::LCD_DISPLAY_ON, 1'b0, lcdws_pkg::HOLD_45,
                      lcdws_pkg::JMP_NEXT, 4'd0, 1'b0};
      4'd5:  word = '{lcdws_pkg::OP_SEND, lcdws_pkg::SRC_CONST,
                      lcdws_pkg::LCD_ERASE_ALL, 1'b0, lcdws_pkg::HOLD_2000,
                      lcdws_pkg::JMP_NEXT, 4'd0, 1'b0};
      4'd6:  word = '{lcdws_pkg::OP_SEND, lcdws_pkg::SRC_CONST,
                      lcdws_pkg::LCD_ENTRY_MODE, 1'b0, lcdws_pkg::HOLD_2000,
                      lcdws_pkg::JMP_NEXT, 4'd0, 1'b1};
      // Single-byte requests.
      4'd7:  word = '{lcdws_pkg::OP_SEND, lcdws_pkg::SRC_INPUT, 8'h00, 1'b0,
                      lcdws_pkg::HOLD_0, lcdws_pkg::JMP_NEXT, 4'd0, 1'b1};
      4'd8:  word = '{lcdws_pkg::OP_SEND, lcdws_pkg::SRC_INPUT, 8'h00, 1'b1,
                      lcdws_pkg::HOLD_0, lcdws_pkg::JMP_NEXT, 4'd0, 1'b1};
      4'd9:  word = '{lcdws_pkg::OP_SEND, lcdws_pkg::SRC_POS,
                      lcdws_pkg::LCD_LINE1_BASE, 1'b0, lcdws_pkg::HOLD_0,
                      lcdws_pkg::JMP_NEXT, 4'd0, 1'b1};
      4'd10: word = '{lcdws_pkg::OP_SEND, lcdws_pkg::SRC_CONST,
                      lcdws_pkg::LCD_ERASE_ALL, 1'b0, lcdws_pkg::HOLD_2000,
                      lcdws_pkg::JMP_NEXT, 4'd0, 1'b1};
      4'd11: word = '{lcdws_pkg::OP_SEND, lcdws_pkg::SRC_SHIFT,
                      lcdws_pkg::LCD_SCROLL_LEFT, 1'b0, lcdws_pkg::HOLD_10000,
                      lcdws_pkg::JMP_NEXT, 4'd0, 1'b1};
      default: word = '{lcdws_pkg::OP_WAIT, lcdws_pkg::SRC_CONST, 8'h00, 1'b0,
                        lcdws_pkg::HOLD_0, lcdws_pkg::JMP_NEXT, 4'd0, 1'b1};
    endcase
  end

endmodule

// File: hw/rtl/lcdws_out_reg.sv
// ----------------------------------------------------------------------------
// lcdws_out_reg
// Output register of the pin-state channel.
// ----------------------------------------------------------------------------
module lcdws_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  lcdws_pkg::out_t din,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output lcdws_pkg::out_t out_data
);

  // A new state may enter when the slot is empty or is being taken now.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= din;
    end
  end

endmodule

// File: hw/rtl/char_lcd_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Expands LCD requests into runs of RS/RW/E/data pin states with hold times.
// ----------------------------------------------------------------------------
// A taken request sets pc and busy; its first pin state is then loaded into
// the output register. One pin state per cycle while the output has room; a
// request of N states (up to 19, init on a 4-bit bus) holds the input until
// its last state loads; an empty run starts nothing. Output stalls hold the
// sequencer. Reset (synchronous, rst high): sequencer idle, output empty,
// four_bit_mode 1, enable_pulse_us 1000.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lcdws_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lcdws_pkg::out_t out_data,
  input  logic            cfg_write,
  input  logic            cfg_index,
  input  logic [9:0]      cfg_data
);

  // Configuration registers.
  logic       four_bit_mode;
  logic [9:0] enable_pulse_us;

  // Sequencer state: busy flag, microcode step counter and the phase within
  // the current step. A step is one microcode word; its phases are the pin
  // states it produces (one for a wait, two per strobe).
  logic       busy;
  logic [3:0] pc;
  logic [1:0] phase;

  // The request being worked on.
  lcdws_pkg::in_t req;

  lcdws_pkg::ucw_t word;
  lcdws_pkg::out_t state_out;
  logic            can_load;
  logic            step;
  logic [1:0]      last_phase;
  logic            runnable;
  logic [7:0]      cur_byte;
  logic [3:0]      next_pc;
  logic            take;

  lcdws_ucode_rom u_rom (
    .addr (pc),
    .word (word)
  );

  // Requests are taken whenever no run is in progress. The final state of a
  // run sits in the output register, so a new request can enter while it
  // still waits to be collected.
  assign in_ready = !busy;
  assign take     = in_valid && in_ready;

  // Unused action codes and positions past column 15 give an empty run; the
  // request is simply taken and nothing is started.
  always_comb begin
    runnable = (in_data.action <= lcdws_pkg::ACT_SHIFT);
    if (in_data.action == lcdws_pkg::ACT_SETPOS &&
        in_data.column > {2'b00, lcdws_pkg::MAX_COLUMN}) begin
      runnable = 1'b0;
    end
  end

  // A state is produced each cycle the output register has room.
  assign step = busy && can_load;

  // Number of states in the current step, minus one.
  always_comb begin
    case (word.op)
      lcdws_pkg::OP_WAIT:   last_phase = 2'd0;
      lcdws_pkg::OP_STROBE: last_phase = 2'd1;
      lcdws_pkg::OP_SEND:   last_phase = four_bit_mode ? 2'd3 : 2'd1;
      default:              last_phase = 2'd0;
    endcase
  end

  // Byte the step works on. The position command is the line base with the
  // column in its low four bits, which is the same as adding them since the
  // column is known to be at most 15 here.
  always_comb begin
    case (word.src)
      lcdws_pkg::SRC_CONST: cur_byte = word.byte_const;
      lcdws_pkg::SRC_INPUT: cur_byte = req.byte_value;
      lcdws_pkg::SRC_POS:   cur_byte = (req.line_select ? lcdws_pkg::LCD_LINE2_BASE
                                                        : lcdws_pkg::LCD_LINE1_BASE)
                                       | {4'h0, req.column[3:0]};
      lcdws_pkg::SRC_SHIFT: cur_byte = word.byte_const
                                       | (req.shift_right ? lcdws_pkg::LCD_SHIFT_BIT
                                                          : 8'h00);
      default:              cur_byte = word.byte_const;
    endcase
  end

  // Branch: the only condition the program tests is the bus width.
  always_comb begin
    case (word.jcond)
      lcdws_pkg::JMP_ALWAYS:  next_pc = word.target;
      lcdws_pkg::JMP_IF_8BIT: next_pc = four_bit_mode ? pc + 4'd1 : word.target;
      default:                next_pc = pc + 4'd1;
    endcase
  end

  // Pin state of the current phase. Even phases raise E for the configured
  // pulse width, odd phases drop it; only the final phase of a step carries
  // the settling delay. In 4-bit mode the first strobe sends the high nibble
  // and the second the low nibble, both on D7..D4.
  always_comb begin
    state_out.reg_select = word.rs;
    state_out.read_write = 1'b0;
    state_out.last       = word.done && (phase == last_phase);
    if (word.op == lcdws_pkg::OP_WAIT) begin
      state_out.enable     = 1'b0;
      state_out.data_lines = 8'h00;
      state_out.hold_us    = lcdws_pkg::hold_value(word.hold_code);
    end else begin
      state_out.enable = !phase[0];
      if (word.op == lcdws_pkg::OP_SEND && four_bit_mode) begin
        state_out.data_lines = phase[1] ? {cur_byte[3:0], 4'h0}
                                        : {cur_byte[7:4], 4'h0};
      end else begin
        state_out.data_lines = cur_byte;
      end
      if (!phase[0]) begin
        state_out.hold_us = {6'd0, enable_pulse_us};
      end else if (phase == last_phase) begin
        state_out.hold_us = lcdws_pkg::hold_value(word.hold_code);
      end else begin
        state_out.hold_us = 16'd0;
      end
    end
  end

  lcdws_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .din       (state_out),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode   <= 1'b1;
      enable_pulse_us <= lcdws_pkg::ENABLE_PULSE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lcdws_pkg::CFG_FOUR_BIT:     four_bit_mode   <= cfg_data[0];
        lcdws_pkg::CFG_ENABLE_PULSE: enable_pulse_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // Step counter and phase counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pc    <= lcdws_pkg::UA_INIT;
      phase <= 2'd0;
    end else if (take) begin
      busy  <= runnable;
      pc    <= lcdws_pkg::entry_addr(in_data.action);
      phase <= 2'd0;
    end else if (step) begin
      if (phase == last_phase) begin
        phase <= 2'd0;
        if (word.done) begin
          busy <= 1'b0;
        end else begin
          pc <= next_pc;
        end
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  // Request fields are held for the whole run.
  always_ff @(posedge clk) begin
    if (take) begin
      req <= in_data;
    end
  end

endmodule
